// File: rtl/scsa_pkg.sv
// Shared types, constants and lookup functions for the size-class slab allocator.
// No dependencies; the top level, controller and datapath import this package.
package scsa_pkg;

    // Geometry of the page pool
    localparam int PAGES      = 64;
    localparam int NUM_CLS    = 9;
    localparam int MAX_OBJS   = 128;
    localparam int PAGE_BYTES = 4096;
    localparam int OBJ_OFF    = 72;
    localparam int NUM_LISTS  = NUM_CLS * 3;

    localparam int ADDR_W   = 39;
    localparam int SIZE_W   = 12;
    localparam int PG_W     = $clog2(PAGES);
    localparam int PTR_W    = PG_W + 1;
    localparam int OBJ_W    = $clog2(MAX_OBJS);
    localparam int CLS_W    = 4;
    localparam int LIST_W   = $clog2(NUM_LISTS);
    localparam int OFF_W    = $clog2(PAGE_BYTES);
    localparam int STRIDE_W = 12;
    localparam int PROD_W   = OBJ_W + STRIDE_W;
    localparam int DSOR_W   = STRIDE_W + OBJ_W - 1;
    localparam int STEP_W   = 3;
    localparam int SLOT_W   = PG_W + OBJ_W;
    localparam int PINFO_W  = CLS_W + OBJ_W + OBJ_W;
    localparam int OBJM_W   = OBJ_W + 1;

    localparam logic [PTR_W-1:0]  PAGE_NIL      = '1;
    localparam logic [OBJ_W-1:0]  OBJ_NIL       = '1;
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 39'h00_8000_0000;
    localparam logic [SIZE_W-1:0] MAX_SIZE      = 12'd2048;

    // List kinds inside one class
    localparam logic [1:0] L_PARTIAL = 2'd0;
    localparam logic [1:0] L_FULL    = 2'd1;
    localparam logic [1:0] L_EMPTY   = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_PAGES = 3'd2,
        ST_FOREIGN  = 3'd3,
        ST_DOUBLE   = 3'd4
    } t_status;

    typedef struct packed {
        logic               kind;
        logic [SIZE_W-1:0]  req_size;
        logic [ADDR_W-1:0]  obj_addr;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0]  result_addr;
        t_status            status;
    } t_out_word;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_BAD,
        CMD_OOP,
        CMD_FOREIGN,
        CMD_DOUBLE,
        CMD_TAKE_PART,
        CMD_TAKE_EMPTY,
        CMD_EMPTY_MOVE,
        CMD_NEW_PAGE,
        CMD_INIT_STEP,
        CMD_POP1,
        CMD_MUL,
        CMD_POP2,
        CMD_FULL_MOVE,
        CMD_F_PAGE,
        CMD_F_CHK,
        CMD_DIV_STEP,
        CMD_F_VAL,
        CMD_F_UPDATE,
        CMD_D_HEAD,
        CMD_D_STEP,
        CMD_D_PUSH,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic walk;     // page-link read follows the walk pointer
    } t_ctl;

    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic part_nil;
        logic empty_nil;
        logic pool_full;
        logic page_foreign;
        logic init_last;
        logic cnt_one;
        logic early_foreign;
        logic div_last;
        logic slot_bad;
        logic in_use;
        logic full_move;
        logic empty_move;
        logic head_stop;
        logic step_stop;
        logic pend;
        logic out_busy;
    } t_sts;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_A_EW,
        S_A_EMPTY,
        S_INIT,
        S_A_IW,
        S_A_POP1,
        S_A_OW,
        S_A_POP2,
        S_A_FW,
        S_A_FULL,
        S_F_IW,
        S_F_CHK,
        S_F_DIV,
        S_F_VAL,
        S_F_OW,
        S_F_OBJ,
        S_D_START,
        S_D_HEAD,
        S_D_RW,
        S_D_STEP,
        S_D_PUSH,
        S_FIN
    } t_state;

    // Slot stride: object size plus 32, padded to 16
    function automatic logic [STRIDE_W-1:0] stride_of(input logic [CLS_W-1:0] cls);
        logic [STRIDE_W-1:0] s;
        unique case (cls)
            4'd0:    s = 12'd48;
            4'd1:    s = 12'd48;
            4'd2:    s = 12'd64;
            4'd3:    s = 12'd96;
            4'd4:    s = 12'd160;
            4'd5:    s = 12'd288;
            4'd6:    s = 12'd544;
            4'd7:    s = 12'd1056;
            4'd8:    s = 12'd2080;
            default: s = 12'd48;
        endcase
        return s;
    endfunction

    // Slots per page for each class
    function automatic logic [OBJ_W-1:0] objs_of(input logic [CLS_W-1:0] cls);
        logic [OBJ_W-1:0] n;
        unique case (cls)
            4'd0:    n = 7'd84;
            4'd1:    n = 7'd84;
            4'd2:    n = 7'd63;
            4'd3:    n = 7'd42;
            4'd4:    n = 7'd25;
            4'd5:    n = 7'd14;
            4'd6:    n = 7'd7;
            4'd7:    n = 7'd3;
            4'd8:    n = 7'd1;
            default: n = 7'd0;
        endcase
        return n;
    endfunction

    // Smallest class that holds the request
    function automatic logic [CLS_W-1:0] cls_of(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] c;
        priority if (size <= 12'd8)    c = 4'd0;
        else if (size <= 12'd16)       c = 4'd1;
        else if (size <= 12'd32)       c = 4'd2;
        else if (size <= 12'd64)       c = 4'd3;
        else if (size <= 12'd128)      c = 4'd4;
        else if (size <= 12'd256)      c = 4'd5;
        else if (size <= 12'd512)      c = 4'd6;
        else if (size <= 12'd1024)     c = 4'd7;
        else                           c = 4'd8;
        return c;
    endfunction

    function automatic logic [LIST_W-1:0] list_idx(input logic [CLS_W-1:0] cls,
                                                   input logic [1:0] kind);
        return LIST_W'(cls) * LIST_W'(3) + LIST_W'(kind);
    endfunction

endpackage

// File: rtl/size_class_slab_allocator_unit.sv
// Top level of the size-class slab allocator: controller plus datapath.
// Depends on scsa_pkg, scsa_ctrl, scsa_dpath (and scsa_ram through the datapath).
//
// One request is handled at a time; the input stalls once a request is accepted
// until the result is in the output register. A rejected size goes straight to
// the result; an allocation is served from a partial page, else from an empty
// page, else from a new page, whose slot free list is built one slot at a time
// (up to 84 slots), and a page going full moves to the full list. A free finds
// its slot with the seven-step offset divider (not when the address lies past
// the pages handed out), and a free that moves its page between lists walks the
// single-port page-link list, twice over for a one-slot page that goes from full
// to empty. A held output word delays the result.
module size_class_slab_allocator_unit import scsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word
);

    t_ctl ctl;
    t_sts sts;

    scsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .o_in_stall(o_in_stall)
    );

    scsa_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_word  (i_in_word),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule

// File: rtl/scsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/scsa_ctrl.sv
// Sequencing state machine of the slab allocator: issues datapath commands.
// Depends on scsa_pkg.
module scsa_ctrl import scsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command
    always_comb begin
        n_state   = r_state;
        o_ctl     = '{cmd: CMD_NOP, walk: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_free) begin
                    if (i_sts.page_foreign) begin
                        o_ctl.cmd = CMD_FOREIGN;
                        n_state   = S_FIN;
                    end else begin
                        o_ctl.cmd = CMD_F_PAGE;
                        n_state   = S_F_IW;
                    end
                end else begin
                    priority if (i_sts.bad_size) begin
                        o_ctl.cmd = CMD_BAD;
                        n_state   = S_FIN;
                    end else if (!i_sts.part_nil) begin
                        o_ctl.cmd = CMD_TAKE_PART;
                        n_state   = S_A_IW;
                    end else if (!i_sts.empty_nil) begin
                        o_ctl.cmd = CMD_TAKE_EMPTY;
                        n_state   = S_A_EW;
                    end else if (i_sts.pool_full) begin
                        o_ctl.cmd = CMD_OOP;
                        n_state   = S_FIN;
                    end else begin
                        o_ctl.cmd = CMD_NEW_PAGE;
                        n_state   = S_INIT;
                    end
                end
            end
            S_A_EW:    n_state = S_A_EMPTY;
            S_A_EMPTY: begin
                o_ctl.cmd = CMD_EMPTY_MOVE;
                n_state   = S_A_IW;
            end
            S_INIT: begin
                o_ctl.cmd = CMD_INIT_STEP;
                if (i_sts.init_last) begin
                    n_state = S_A_IW;
                end
            end
            S_A_IW:    n_state = S_A_POP1;
            S_A_POP1: begin
                o_ctl.cmd = CMD_POP1;
                n_state   = S_A_OW;
            end
            S_A_OW: begin
                o_ctl.cmd = CMD_MUL;
                n_state   = S_A_POP2;
            end
            S_A_POP2: begin
                o_ctl.cmd = CMD_POP2;
                n_state   = i_sts.cnt_one ? S_A_FW : S_FIN;
            end
            S_A_FW:    n_state = S_A_FULL;
            S_A_FULL: begin
                o_ctl.cmd = CMD_FULL_MOVE;
                n_state   = S_FIN;
            end
            S_F_IW:    n_state = S_F_CHK;
            S_F_CHK: begin
                if (i_sts.early_foreign) begin
                    o_ctl.cmd = CMD_FOREIGN;
                    n_state   = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_F_CHK;
                    n_state   = S_F_DIV;
                end
            end
            S_F_DIV: begin
                o_ctl.cmd = CMD_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_F_VAL;
                end
            end
            S_F_VAL: begin
                if (i_sts.slot_bad) begin
                    o_ctl.cmd = CMD_FOREIGN;
                    n_state   = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_F_VAL;
                    n_state   = S_F_OW;
                end
            end
            S_F_OW:    n_state = S_F_OBJ;
            S_F_OBJ: begin
                if (!i_sts.in_use) begin
                    o_ctl.cmd = CMD_DOUBLE;
                    n_state   = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_F_UPDATE;
                    n_state   = (i_sts.full_move || i_sts.empty_move) ? S_D_START : S_FIN;
                end
            end
            // unlink page from one list, push it on another
            S_D_START: n_state = S_D_HEAD;
            S_D_HEAD: begin
                o_ctl.cmd = CMD_D_HEAD;
                n_state   = i_sts.head_stop ? S_D_PUSH : S_D_RW;
            end
            S_D_RW: begin
                o_ctl.walk = 1'b1;
                n_state    = S_D_STEP;
            end
            S_D_STEP: begin
                o_ctl.cmd = CMD_D_STEP;
                n_state   = i_sts.step_stop ? S_D_PUSH : S_D_RW;
            end
            S_D_PUSH: begin
                o_ctl.cmd = CMD_D_PUSH;
                n_state   = i_sts.pend ? S_D_START : S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_ctl.cmd = CMD_EMIT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/scsa_dpath.sv
// Datapath of the slab allocator: list heads, page and slot RAMs, divider, output word.
// Depends on scsa_pkg and scsa_ram.
module scsa_dpath import scsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    input  t_in_word          i_in_word,
    input  t_ctl              i_ctl,
    output t_sts              o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word
);

    logic [ADDR_W-1:0]   r_heap_base;
    logic                r_kind;
    logic                r_bad;
    logic [CLS_W-1:0]    r_cls;
    logic [ADDR_W-1:0]   r_diff;
    logic [PG_W-1:0]     r_page;
    logic [OBJ_W-1:0]    r_obj;
    logic [OBJ_W-1:0]    r_cnt;
    logic [OBJ_W-1:0]    r_head;
    logic [PROD_W-1:0]   r_prod;
    logic [OFF_W-1:0]    r_rem;
    logic [DSOR_W-1:0]   r_dsor;
    logic [OBJ_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_dstep;
    logic [PTR_W-1:0]    r_cur;
    logic [PTR_W-1:0]    r_plink;
    logic [LIST_W-1:0]   r_ld;
    logic [LIST_W-1:0]   r_lp;
    logic                r_pend;
    logic [OBJ_W-1:0]    r_init_i;
    logic [PTR_W-1:0]    r_pages_used;
    logic [PTR_W-1:0]    r_heads [NUM_LISTS];
    logic [ADDR_W-1:0]   r_addr;
    t_status             r_status;
    logic                r_out_valid;
    t_out_word           r_out;

    // RAM ports
    logic                pinfo_we;
    logic [PINFO_W-1:0]  pinfo_wdata;
    logic [PINFO_W-1:0]  pinfo_rdata;
    logic                plink_we;
    logic [PG_W-1:0]     plink_waddr;
    logic [PTR_W-1:0]    plink_wdata;
    logic [PG_W-1:0]     plink_raddr;
    logic [PTR_W-1:0]    plink_rdata;
    logic                obj_we;
    logic [SLOT_W-1:0]   obj_waddr;
    logic [OBJM_W-1:0]   obj_wdata;
    logic [OBJM_W-1:0]   obj_rdata;

    logic [CLS_W-1:0]    pi_cls;
    logic [OBJ_W-1:0]    pi_cnt;
    logic [OBJ_W-1:0]    pi_head;
    logic [LIST_W-1:0]   idx_part;
    logic [LIST_W-1:0]   idx_full;
    logic [LIST_W-1:0]   idx_empty;
    logic [PTR_W-1:0]    page_ptr;
    logic [OBJ_W-1:0]    n_objs;
    logic [OFF_W-1:0]    off;
    logic                ge;
    logic [DSOR_W:0]     page_off;

    assign pi_cls    = pinfo_rdata[PINFO_W-1 -: CLS_W];
    assign pi_cnt    = pinfo_rdata[OBJ_W +: OBJ_W];
    assign pi_head   = pinfo_rdata[OBJ_W-1:0];
    assign idx_part  = list_idx(r_cls, L_PARTIAL);
    assign idx_full  = list_idx(r_cls, L_FULL);
    assign idx_empty = list_idx(r_cls, L_EMPTY);
    assign page_ptr  = {1'b0, r_page};
    assign n_objs    = objs_of(r_cls);
    assign off       = r_diff[OFF_W-1:0];
    assign ge        = ({{(DSOR_W-OFF_W){1'b0}}, r_rem} >= r_dsor);
    assign page_off  = {r_page, {OFF_W{1'b0}}} + (DSOR_W+1)'(OBJ_OFF)
                     + (DSOR_W+1)'(r_prod);
    assign plink_raddr = i_ctl.walk ? r_cur[PG_W-1:0] : r_page;

    scsa_ram #(.WIDTH(PINFO_W), .DEPTH(PAGES)) u_pinfo (
        .i_clk  (i_clk),
        .i_we   (pinfo_we),
        .i_waddr(r_page),
        .i_wdata(pinfo_wdata),
        .i_raddr(r_page),
        .o_rdata(pinfo_rdata)
    );

    scsa_ram #(.WIDTH(PTR_W), .DEPTH(PAGES)) u_plink (
        .i_clk  (i_clk),
        .i_we   (plink_we),
        .i_waddr(plink_waddr),
        .i_wdata(plink_wdata),
        .i_raddr(plink_raddr),
        .o_rdata(plink_rdata)
    );

    scsa_ram #(.WIDTH(OBJM_W), .DEPTH(PAGES * MAX_OBJS)) u_obj (
        .i_clk  (i_clk),
        .i_we   (obj_we),
        .i_waddr(obj_waddr),
        .i_wdata(obj_wdata),
        .i_raddr({r_page, r_obj}),
        .o_rdata(obj_rdata)
    );

    // RAM write selection
    always_comb begin
        pinfo_we    = 1'b0;
        pinfo_wdata = {r_cls, r_cnt, r_obj};
        plink_we    = 1'b0;
        plink_waddr = r_page;
        plink_wdata = r_heads[idx_part];
        obj_we      = 1'b0;
        obj_waddr   = {r_page, r_obj};
        obj_wdata   = {1'b0, r_head};
        unique case (i_ctl.cmd)
            CMD_INIT_STEP: begin
                obj_we    = 1'b1;
                obj_waddr = {r_page, r_init_i};
                obj_wdata = {1'b0, (r_init_i == '0) ? OBJ_NIL : r_init_i - 1'b1};
                if (r_init_i == n_objs - 1'b1) begin
                    pinfo_we    = 1'b1;
                    pinfo_wdata = {r_cls, n_objs, r_init_i};
                    plink_we    = 1'b1;
                end
            end
            CMD_EMPTY_MOVE: plink_we = 1'b1;
            CMD_POP2: begin
                obj_we      = 1'b1;
                obj_wdata   = {1'b1, obj_rdata[OBJ_W-1:0]};
                pinfo_we    = 1'b1;
                pinfo_wdata = {r_cls, r_cnt - 1'b1, obj_rdata[OBJ_W-1:0]};
            end
            CMD_FULL_MOVE: begin
                plink_we    = 1'b1;
                plink_wdata = r_heads[idx_full];
            end
            CMD_F_UPDATE: begin
                obj_we      = 1'b1;
                pinfo_we    = 1'b1;
                pinfo_wdata = {r_cls, r_cnt + 1'b1, r_obj};
            end
            CMD_D_STEP: begin
                plink_we    = (plink_rdata == page_ptr);
                plink_waddr = r_cur[PG_W-1:0];
                plink_wdata = r_plink;
            end
            CMD_D_PUSH: begin
                plink_we    = 1'b1;
                plink_wdata = r_heads[r_lp];
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= HEAP_BASE_RST;
            r_pages_used <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_heads[i] <= PAGE_NIL;
            end
        end else begin
            if (i_cfg_we) begin
                r_heap_base <= i_cfg_wdata;
            end
            // a new result takes over the output register in the emit branch
            if (o_out_valid && !i_out_stall && (i_ctl.cmd != CMD_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_kind   <= i_in_word.kind;
                    r_cls    <= cls_of(i_in_word.req_size);
                    r_bad    <= (i_in_word.req_size == '0) || (i_in_word.req_size > MAX_SIZE);
                    r_diff   <= i_in_word.obj_addr - r_heap_base;
                    r_addr   <= '0;
                    r_status <= ST_OK;
                end
                CMD_BAD:        r_status <= ST_BAD_SIZE;
                CMD_OOP:        r_status <= ST_NO_PAGES;
                CMD_FOREIGN:    r_status <= ST_FOREIGN;
                CMD_DOUBLE:     r_status <= ST_DOUBLE;
                CMD_TAKE_PART:  r_page <= r_heads[idx_part][PG_W-1:0];
                CMD_TAKE_EMPTY: r_page <= r_heads[idx_empty][PG_W-1:0];
                CMD_EMPTY_MOVE: begin
                    r_heads[idx_empty] <= plink_rdata;
                    r_heads[idx_part]  <= page_ptr;
                end
                CMD_NEW_PAGE: begin
                    r_page       <= r_pages_used[PG_W-1:0];
                    r_pages_used <= r_pages_used + 1'b1;
                    r_init_i     <= '0;
                end
                CMD_INIT_STEP: begin
                    r_init_i <= r_init_i + 1'b1;
                    if (r_init_i == n_objs - 1'b1) begin
                        r_heads[idx_part] <= page_ptr;
                    end
                end
                CMD_POP1: begin
                    r_obj <= pi_head;
                    r_cnt <= pi_cnt;
                end
                CMD_MUL: r_prod <= PROD_W'(r_obj) * PROD_W'(stride_of(r_cls));
                CMD_POP2: r_addr <= r_heap_base + ADDR_W'(page_off);
                CMD_FULL_MOVE: begin
                    r_heads[idx_part] <= plink_rdata;
                    r_heads[idx_full] <= page_ptr;
                end
                CMD_F_PAGE: r_page <= r_diff[OFF_W +: PG_W];
                CMD_F_CHK: begin
                    r_cls   <= pi_cls;
                    r_cnt   <= pi_cnt;
                    r_head  <= pi_head;
                    r_rem   <= off - OFF_W'(OBJ_OFF);
                    r_dsor  <= DSOR_W'(stride_of(pi_cls)) << (OBJ_W - 1);
                    r_quo   <= '0;
                    r_dstep <= STEP_W'(OBJ_W - 1);
                end
                // one restoring-division step per cycle
                CMD_DIV_STEP: begin
                    if (ge) begin
                        r_rem <= r_rem - r_dsor[OFF_W-1:0];
                    end
                    r_quo   <= {r_quo[OBJ_W-2:0], ge};
                    r_dsor  <= r_dsor >> 1;
                    r_dstep <= r_dstep - 1'b1;
                end
                CMD_F_VAL: r_obj <= r_quo;
                CMD_F_UPDATE: begin
                    if (r_cnt == '0) begin
                        r_ld   <= idx_full;
                        r_lp   <= idx_part;
                        r_pend <= (r_cnt + 1'b1 == n_objs);
                    end else begin
                        r_ld   <= idx_part;
                        r_lp   <= idx_empty;
                        r_pend <= 1'b0;
                    end
                end
                CMD_D_HEAD: begin
                    r_plink <= plink_rdata;
                    r_cur   <= r_heads[r_ld];
                    if (r_heads[r_ld] == page_ptr) begin
                        r_heads[r_ld] <= plink_rdata;
                    end
                end
                CMD_D_STEP: r_cur <= plink_rdata;
                CMD_D_PUSH: begin
                    r_heads[r_lp] <= page_ptr;
                    if (r_pend) begin
                        r_ld   <= idx_part;
                        r_lp   <= idx_empty;
                        r_pend <= 1'b0;
                    end
                end
                CMD_EMIT: begin
                    r_out       <= '{result_addr: r_addr, status: r_status};
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Status toward the controller
    always_comb begin
        o_sts.is_free       = r_kind;
        o_sts.bad_size      = r_bad;
        o_sts.part_nil      = (r_heads[idx_part] >= PTR_W'(PAGES));
        o_sts.empty_nil     = (r_heads[idx_empty] >= PTR_W'(PAGES));
        o_sts.pool_full     = (r_pages_used >= PTR_W'(PAGES));
        o_sts.page_foreign  = (r_diff[ADDR_W-1:OFF_W] >= (ADDR_W-OFF_W)'(r_pages_used));
        o_sts.init_last     = (r_init_i == n_objs - 1'b1);
        o_sts.cnt_one       = (r_cnt == OBJ_W'(1));
        o_sts.early_foreign = (off < OFF_W'(OBJ_OFF)) || (pi_cls >= CLS_W'(NUM_CLS));
        o_sts.div_last      = (r_dstep == '0);
        o_sts.slot_bad      = (r_rem != '0) || (r_quo >= n_objs);
        o_sts.in_use        = obj_rdata[OBJM_W-1];
        o_sts.full_move     = (r_cnt == '0);
        o_sts.empty_move    = (r_cnt + 1'b1 == n_objs);
        o_sts.head_stop     = (r_heads[r_ld] == page_ptr) || (r_heads[r_ld] >= PTR_W'(PAGES));
        o_sts.step_stop     = (plink_rdata == page_ptr) || (plink_rdata >= PTR_W'(PAGES));
        o_sts.pend          = r_pend;
        o_sts.out_busy      = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cmd == CMD_EMIT |-> !(r_out_valid && i_out_stall))
        else $error("result word overwritten while held");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cmd == CMD_EMIT |=> r_out_valid)
        else $error("result not presented after emit");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_ctl.cmd == CMD_EMIT))
        else $error("result valid without emit");

    a_pool_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages_used != $past(r_pages_used) |-> $past(i_ctl.cmd == CMD_NEW_PAGE))
        else $error("page pool changed outside page grant");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cmd == CMD_NEW_PAGE |-> r_pages_used < PTR_W'(PAGES))
        else $error("page granted from exhausted pool");

endmodule
